// File: hdl/crm_pkg.sv
`default_nettype none
package crm_pkg;

  localparam int unsigned CoefWidth      = 16;
  localparam int unsigned ResultWidth    = 32;
  localparam int unsigned ResultFracBits = 16;

  // determinant of 3x3 with CoefWidth entries, plus headroom for the sum
  localparam int unsigned DetWidth  = 3 * CoefWidth + 3;
  localparam int unsigned NumWidth  = DetWidth + ResultFracBits;
  localparam int unsigned WideWidth = (DetWidth + ResultWidth > NumWidth) ?
                                      DetWidth + ResultWidth : NumWidth;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_r1_c1;
    logic signed [CoefWidth-1:0] coef_r1_c2;
    logic signed [CoefWidth-1:0] coef_r1_c3;
    logic signed [CoefWidth-1:0] coef_r2_c1;
    logic signed [CoefWidth-1:0] coef_r2_c2;
    logic signed [CoefWidth-1:0] coef_r2_c3;
    logic signed [CoefWidth-1:0] coef_r3_c1;
    logic signed [CoefWidth-1:0] coef_r3_c2;
    logic signed [CoefWidth-1:0] coef_r3_c3;
    logic signed [CoefWidth-1:0] rhs_r1;
    logic signed [CoefWidth-1:0] rhs_r2;
    logic signed [CoefWidth-1:0] rhs_r3;
  } crm_in_t;

  typedef struct packed {
    logic signed [ResultWidth-1:0] sol_x;
    logic signed [ResultWidth-1:0] sol_y;
    logic signed [ResultWidth-1:0] sol_z;
    logic                          singular;
    logic                          saturated;
  } crm_out_t;

  // determinants handed from front to back
  typedef struct packed {
    logic [DetWidth-1:0]      det;
    logic [2:0][DetWidth-1:0] num;
    logic                     singular;
  } crm_job_t;

endpackage
`default_nettype wire

// File: hdl/crm_front.sv
`default_nettype none
module crm_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  output logic                   rdy_o,
  input  wire crm_pkg::crm_in_t  item_i,
  output logic                   vld_o,
  input  wire logic              rdy_i,
  output crm_pkg::crm_job_t      job_o
);
  import crm_pkg::*;

  localparam int unsigned PW = 2 * CoefWidth;
  localparam int unsigned CofW = 2 * CoefWidth + 1;
  localparam int unsigned TW = 3 * CoefWidth + 1;

  logic signed [CoefWidth-1:0] a [9];
  logic signed [CoefWidth-1:0] b [3];
  logic signed [CoefWidth-1:0] mat [4][9];

  logic signed [PW-1:0]        p1_q [4][6];
  logic signed [CoefWidth-1:0] r1_q [4][3];
  logic signed [CofW-1:0]      c2_q [4][3];
  logic signed [CoefWidth-1:0] r2_q [4][3];
  logic signed [TW-1:0]        t3_q [4][3];
  logic [3:0]                  vld_q;
  crm_job_t                    job_q;
  logic                        en;

  assign en    = !vld_q[3] || rdy_i;
  assign rdy_o = en;
  assign vld_o = vld_q[3];
  assign job_o = job_q;

  always_comb begin
    a[0] = item_i.coef_r1_c1; a[1] = item_i.coef_r1_c2; a[2] = item_i.coef_r1_c3;
    a[3] = item_i.coef_r2_c1; a[4] = item_i.coef_r2_c2; a[5] = item_i.coef_r2_c3;
    a[6] = item_i.coef_r3_c1; a[7] = item_i.coef_r3_c2; a[8] = item_i.coef_r3_c3;
    b[0] = item_i.rhs_r1; b[1] = item_i.rhs_r2; b[2] = item_i.rhs_r3;
    // matrix 0 is A, matrix k has column k replaced by the right-hand side
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 9; r++) begin
        mat[k][r] = a[r];
      end
    end
    for (int k = 1; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        mat[k][r*3 + k - 1] = b[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p1_q[k][0] <= PW'(mat[k][4]) * PW'(mat[k][8]);
        p1_q[k][1] <= PW'(mat[k][5]) * PW'(mat[k][7]);
        p1_q[k][2] <= PW'(mat[k][3]) * PW'(mat[k][8]);
        p1_q[k][3] <= PW'(mat[k][5]) * PW'(mat[k][6]);
        p1_q[k][4] <= PW'(mat[k][3]) * PW'(mat[k][7]);
        p1_q[k][5] <= PW'(mat[k][4]) * PW'(mat[k][6]);
        for (int j = 0; j < 3; j++) begin
          r1_q[k][j] <= mat[k][j];
          c2_q[k][j] <= CofW'(p1_q[k][2*j]) - CofW'(p1_q[k][2*j+1]);
          r2_q[k][j] <= r1_q[k][j];
          t3_q[k][j] <= TW'(r2_q[k][j]) * TW'(c2_q[k][j]);
        end
      end
      job_q.det <= DetWidth'(t3_q[0][0]) - DetWidth'(t3_q[0][1]) + DetWidth'(t3_q[0][2]);
      for (int k = 0; k < 3; k++) begin
        job_q.num[k] <= DetWidth'(t3_q[k+1][0]) - DetWidth'(t3_q[k+1][1])
                      + DetWidth'(t3_q[k+1][2]);
      end
      job_q.singular <= (DetWidth'(t3_q[0][0]) - DetWidth'(t3_q[0][1])
                         + DetWidth'(t3_q[0][2])) == '0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/crm_queue.sv
`default_nettype none
module crm_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  output logic                   full_o,
  input  wire crm_pkg::crm_job_t wdata_i,
  output logic                   nempty_o,
  input  wire logic              rd_i,
  output crm_pkg::crm_job_t      rdata_o
);
  import crm_pkg::*;

  crm_job_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_wr, do_rd;

  assign full_o   = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign nempty_o = cnt_q != '0;
  assign rdata_o  = mem_q[rp_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && nempty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (QueuePtrW+1)'(QueueDepth)) |-> wp_q == rp_q)
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a write");

endmodule
`default_nettype wire

// File: hdl/crm_back.sv
`default_nettype none
module crm_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  output logic                   rdy_o,
  input  wire crm_pkg::crm_job_t job_i,
  output logic                   vld_o,
  input  wire logic              rdy_i,
  output crm_pkg::crm_out_t      res_o
);
  import crm_pkg::*;

  localparam int unsigned NS = ResultWidth + 1;

  logic [NumWidth-1:0]    rem_q [NS][3];
  logic [ResultWidth-1:0] quo_q [NS][3];
  logic [2:0]             neg_q [NS];
  logic [2:0]             ovf_q [NS];
  logic [DetWidth-1:0]    dm_q  [NS];
  logic [NS-1:0]          sng_q;
  logic [NS-1:0]          vld_q;
  logic                   out_vld_q;
  crm_out_t               out_q;
  logic                   en;

  logic [DetWidth-1:0]    dm, nabs;
  logic [NumWidth-1:0]    nm [3];
  logic [2:0]             neg, ovf;
  logic [ResultWidth-1:0] lim, mag;
  logic [ResultWidth-1:0] sol [3];
  logic                   sat;

  assign en    = !out_vld_q || rdy_i;
  assign rdy_o = en;
  assign vld_o = out_vld_q;
  assign res_o = out_q;

  always_comb begin
    dm = job_i.det[DetWidth-1] ? -job_i.det : job_i.det;
    for (int k = 0; k < 3; k++) begin
      nabs   = job_i.num[k][DetWidth-1] ? -job_i.num[k] : job_i.num[k];
      nm[k]  = NumWidth'(nabs) << ResultFracBits;
      neg[k] = job_i.num[k][DetWidth-1] ^ job_i.det[DetWidth-1];
      // quotient needs more than ResultWidth bits
      ovf[k] = WideWidth'(nm[k]) >= (WideWidth'(dm) << ResultWidth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NS-2:0], vld_i};
      out_vld_q <= vld_q[NS-1];
    end
  end

  // restoring division, one quotient bit per stage, msb first
  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q[0]  <= dm;
      sng_q[0] <= job_i.singular;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= nm[k];
        quo_q[0][k] <= '0;
      end
      for (int s = 1; s < NS; s++) begin
        dm_q[s]  <= dm_q[s-1];
        sng_q[s] <= sng_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        for (int k = 0; k < 3; k++) begin
          if (WideWidth'(rem_q[s-1][k]) >= (WideWidth'(dm_q[s-1]) << (ResultWidth - s))) begin
            rem_q[s][k] <= NumWidth'(WideWidth'(rem_q[s-1][k])
                           - (WideWidth'(dm_q[s-1]) << (ResultWidth - s)));
            quo_q[s][k] <= quo_q[s-1][k] | (ResultWidth'(1) << (ResultWidth - s));
          end else begin
            rem_q[s][k] <= rem_q[s-1][k];
            quo_q[s][k] <= quo_q[s-1][k];
          end
        end
      end
    end
  end

  always_comb begin
    sat = 1'b0;
    lim = '0;
    mag = '0;
    for (int k = 0; k < 3; k++) begin
      lim = (ResultWidth'(1) << (ResultWidth - 1)) - ResultWidth'(!neg_q[NS-1][k]);
      mag = quo_q[NS-1][k];
      if (ovf_q[NS-1][k] || mag > lim) begin
        mag = lim;
        sat = 1'b1;
      end
      sol[k] = neg_q[NS-1][k] ? -mag : mag;
      if (sng_q[NS-1]) begin
        sol[k] = '0;
      end
    end
    if (sng_q[NS-1]) begin
      sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.sol_x     <= sol[0];
      out_q.sol_y     <= sol[1];
      out_q.sol_z     <= sol[2];
      out_q.singular  <= sng_q[NS-1];
      out_q.saturated <= sat;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cramer_3x3_solver_core.sv
`default_nettype none
// Solves one 3x3 system A*v = b by Cramer's rule per item, Q8.8 in, Q16.16 out,
// quotients truncated toward zero and clamped (saturated flag); a zero main
// determinant gives zero results with singular set. One item is accepted per
// clock while full is low. Registered multipliers and adders (products,
// cofactors, terms, sums) form the four determinants, a four-entry queue
// follows, then a setup stage, a 32-stage restoring divider (one quotient bit
// per stage for each of the three unknowns) and the result register.
module cramer_3x3_solver_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire crm_pkg::crm_in_t item_i,
  output logic                  empty,
  input  wire logic             pop,
  output crm_pkg::crm_out_t     result_o
);
  import crm_pkg::*;

  logic     f_rdy, f_vld, q_full, q_nempty, b_rdy, b_vld;
  crm_job_t f_job, q_job;

  assign full  = !f_rdy;
  assign empty = !b_vld;

  crm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (push),
    .rdy_o  (f_rdy),
    .item_i (item_i),
    .vld_o  (f_vld),
    .rdy_i  (!q_full),
    .job_o  (f_job)
  );

  crm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (f_vld),
    .full_o   (q_full),
    .wdata_i  (f_job),
    .nempty_o (q_nempty),
    .rd_i     (b_rdy),
    .rdata_o  (q_job)
  );

  crm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (q_nempty),
    .rdy_o  (b_rdy),
    .job_i  (q_job),
    .vld_o  (b_vld),
    .rdy_i  (pop),
    .res_o  (result_o)
  );

endmodule
`default_nettype wire
